/* sv/particle_store_euler_step_core_macros.svh */
// Assertion helpers
`ifndef PARTICLE_STORE_EULER_STEP_CORE_MACROS_SVH
`define PARTICLE_STORE_EULER_STEP_CORE_MACROS_SVH
`define PSE_ASSERT_IMP(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
`define PSE_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

/* sv/pse_pkg.sv */
`default_nettype none
package pse_pkg;
    localparam int MaxParticles = 64;
    localparam int SlotW = 6;
    localparam int CountW = 7;
    localparam logic [1:0] FUNC_EMIT  = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [0:0] REG_GRAVITY  = 1'd0;
    localparam logic [0:0] REG_CAPACITY = 1'd1;
    localparam logic [23:0] GravityReset = 24'd642253;
    localparam logic [6:0] CapacityReset = 7'd64;
    // particle record: pos xyz, vel xyz, rgba, size, life, age
    localparam int RecW = 32 * 9 + 16;
endpackage
`default_nettype wire

/* sv/pse_ram.sv */
`default_nettype none
module pse_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* sv/pse_divider.sv */
`default_nettype none
// Restoring divider: 8-bit quotient of num / den where num < 256*den; one bit per cycle.
module pse_divider
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [39:0] num,
    input  wire logic [31:0] den,
    output logic             busy,
    output logic [7:0]       quo
);
    logic [39:0] rem_reg;
    logic [31:0] den_reg;
    logic [3:0]  cnt_reg;
    logic [7:0]  quo_reg;
    logic [3:0]  bit_idx;
    logic [40:0] trial;

    assign bit_idx = cnt_reg - 4'd1;
    assign trial = {1'b0, rem_reg} - ({9'd0, den_reg} << bit_idx);
    assign busy = (cnt_reg != 4'd0);
    assign quo = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 4'd0;
            rem_reg <= 40'd0;
            den_reg <= 32'd0;
            quo_reg <= 8'd0;
        end
        else if (start)
        begin
            cnt_reg <= 4'd8;
            rem_reg <= num;
            den_reg <= den;
            quo_reg <= 8'd0;
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 4'd1;
            // keep the remainder when the shifted divisor fits
            if (!trial[40])
            begin
                rem_reg <= trial[39:0];
                quo_reg <= quo_reg | (8'd1 << bit_idx);
            end
        end
    end
endmodule
`default_nettype wire

/* sv/particle_store_euler_step_core.sv */
`default_nettype none
// Particle store with Euler step. Input is ready only when the block is idle and its result
// register is empty; one item is worked on at a time. Emit makes one RAM write per accepted
// copy; clear and unknown commands go straight to the result. A tick first forms gravity
// times step, then walks every stored particle: a particle that expires is only read and
// loaded; a survivor is read, loaded, multiplied axis by axis on one shared 33x22
// multiplier while the alpha divider runs, waits for the divider and is written back
// compacted in place, and each survivor after the first then hands on the previous one.
// Each result is held back by one survivor so that last can be set on the final one.
// A stalled output stalls the walk.
module particle_store_euler_step_core
    import pse_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [0:0]   cfg_index,
    input  wire logic [23:0]  cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // lsb up: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, rgba, point_size, life_span,
    // copies, time_step, pad
    input  wire logic [303:0] s_axis_tdata,
    input  wire logic [1:0]   s_axis_tuser,  // func
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // lsb up: out_x, out_y, out_z, out_rgba, out_size, accepted, pad
    output logic [151:0]      m_axis_tdata,
    output logic              m_axis_tuser,  // has_particle
    output logic              m_axis_tlast   // last
);
    localparam logic [3:0] S_IDLE = 4'd0, S_EMIT = 4'd1, S_FALL = 4'd2, S_RD = 4'd3,
        S_LOAD = 4'd4, S_MUL = 4'd5, S_DIV = 4'd6, S_WB = 4'd7, S_OUT = 4'd8,
        S_LAST = 4'd9, S_DONE = 4'd10;

    logic [3:0]      state_reg;
    logic [23:0]     gravity_reg;
    logic [6:0]      cap_reg;
    logic [6:0]      live_reg, idx_reg, keep_reg, left_reg;
    logic [1:0]      axis_reg;
    logic [271:0]    in_reg;
    logic [20:0]     dt_reg;
    logic [31:0]     fall_reg;
    logic [31:0]     step_reg;
    logic [RecW-1:0] rec_reg;
    logic [31:0]     px_reg, py_reg, pz_reg;
    logic [143:0]    pend_reg;
    logic            pend_valid_reg;
    logic [151:0]    out_data_reg;
    logic            out_user_reg, out_last_reg, out_valid_reg;

    // record layout: pos xyz [95:0], vel xyz [191:96], rgba [223:192], size [239:224],
    // life [271:240], age [303:272]
    logic            ram_we;
    logic [SlotW-1:0] ram_waddr;
    logic [RecW-1:0] ram_wdata, ram_rdata;
    pse_ram #(.Width(RecW), .Depth(MaxParticles)) u_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(idx_reg[SlotW-1:0]), .rdata(ram_rdata));

    // shared multiplier: signed 33 x 22
    logic signed [32:0] mul_a;
    logic signed [21:0] mul_b;
    logic signed [54:0] mul_p;
    assign mul_b = {1'b0, dt_reg};
    assign mul_p = mul_a * mul_b;

    logic        div_start, div_busy;
    logic [7:0]  div_q;
    logic [31:0] life_left;
    logic [39:0] div_num;
    assign life_left = rec_reg[271:240] - rec_reg[303:272];
    // 255 * (life - age)
    assign div_num = {life_left, 8'd0} - {8'd0, life_left};
    assign div_start = (state_reg == S_MUL) && (axis_reg == 2'd0);
    pse_divider u_div (.clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
        .den(rec_reg[271:240]), .busy(div_busy), .quo(div_q));

    logic [32:0] age_sum;
    logic [31:0] age_sat;
    logic [6:0]  cap_eff, room, n_emit, copies;
    assign age_sum = {1'b0, ram_rdata[303:272]} + {12'd0, dt_reg};
    assign age_sat = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
    assign cap_eff = (cap_reg > 7'(MaxParticles)) ? 7'(MaxParticles) : cap_reg;
    assign room = (live_reg < cap_eff) ? cap_eff - live_reg : 7'd0;
    assign copies = s_axis_tdata[278:272];
    assign n_emit = (copies > room) ? room : copies;

    // updated survivor: size, rgba with faded alpha, z, y, x
    logic [143:0] new_item;
    logic [31:0]  new_vy;
    assign new_vy = rec_reg[159:128] - fall_reg;
    assign new_item = {rec_reg[239:224], rec_reg[223:200], div_q, pz_reg, py_reg, px_reg};

    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;
    assign m_axis_tuser = out_user_reg;
    assign m_axis_tlast = out_last_reg;

    always_comb
    begin
        case (axis_reg)
            2'd1:
            begin
                mul_a = {rec_reg[159], rec_reg[159:128]};
            end
            2'd2:
            begin
                mul_a = {rec_reg[191], rec_reg[191:160]};
            end
            default:
            begin
                mul_a = {rec_reg[127], rec_reg[127:96]};
            end
        endcase
        if (state_reg == S_FALL)
        begin
            mul_a = {9'd0, gravity_reg};
        end
    end

    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = keep_reg[SlotW-1:0];
        ram_wdata = {rec_reg[303:224], rec_reg[223:200], div_q, rec_reg[191:160], new_vy,
            rec_reg[127:96], pz_reg, py_reg, px_reg};
        if (state_reg == S_EMIT)
        begin
            ram_we = 1'b1;
            ram_waddr = live_reg[SlotW-1:0];
            ram_wdata = {32'd0, in_reg};
        end
        else if (state_reg == S_WB)
        begin
            ram_we = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            gravity_reg <= GravityReset;
            cap_reg <= CapacityReset;
            live_reg <= 7'd0;
            idx_reg <= 7'd0;
            keep_reg <= 7'd0;
            left_reg <= 7'd0;
            axis_reg <= 2'd0;
            in_reg <= '0;
            dt_reg <= 21'd0;
            fall_reg <= 32'd0;
            step_reg <= 32'd0;
            rec_reg <= '0;
            px_reg <= 32'd0;
            py_reg <= 32'd0;
            pz_reg <= 32'd0;
            pend_reg <= '0;
            pend_valid_reg <= 1'b0;
            out_data_reg <= '0;
            out_user_reg <= 1'b0;
            out_last_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_GRAVITY)
                begin
                    gravity_reg <= cfg_data;
                end
                else if (cfg_index == REG_CAPACITY)
                begin
                    cap_reg <= cfg_data[6:0];
                end
            end
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        in_reg <= s_axis_tdata[271:0];
                        dt_reg <= s_axis_tdata[299:279];
                        out_user_reg <= 1'b0;
                        out_last_reg <= 1'b1;
                        idx_reg <= 7'd0;
                        keep_reg <= 7'd0;
                        case (s_axis_tuser)
                            FUNC_EMIT:
                            begin
                                out_data_reg <= {1'b0, n_emit, 144'd0};
                                left_reg <= n_emit;
                                state_reg <= (n_emit == 7'd0) ? S_DONE : S_EMIT;
                            end
                            FUNC_TICK:
                            begin
                                out_data_reg <= '0;
                                state_reg <= S_FALL;
                            end
                            FUNC_CLEAR:
                            begin
                                out_data_reg <= '0;
                                live_reg <= 7'd0;
                                state_reg <= S_DONE;
                            end
                            default:
                            begin
                                out_data_reg <= '0;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_EMIT:
                begin
                    live_reg <= live_reg + 7'd1;
                    left_reg <= left_reg - 7'd1;
                    if (left_reg == 7'd1)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_FALL:
                begin
                    fall_reg <= mul_p[47:16];
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    if (idx_reg == live_reg)
                    begin
                        live_reg <= keep_reg;
                        state_reg <= pend_valid_reg ? S_LAST : S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    rec_reg <= {age_sat, ram_rdata[271:0]};
                    idx_reg <= idx_reg + 7'd1;
                    axis_reg <= 2'd0;
                    // drop a particle whose age reaches its lifetime
                    state_reg <= (age_sat >= ram_rdata[271:240]) ? S_RD : S_MUL;
                end
                S_MUL:
                begin
                    // multiply one axis while adding the previous one
                    step_reg <= mul_p[47:16];
                    axis_reg <= axis_reg + 2'd1;
                    case (axis_reg)
                        2'd1:
                        begin
                            px_reg <= rec_reg[31:0] + step_reg;
                        end
                        2'd2:
                        begin
                            py_reg <= rec_reg[63:32] + step_reg;
                        end
                        2'd3:
                        begin
                            pz_reg <= rec_reg[95:64] + step_reg;
                            state_reg <= S_DIV;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_DIV:
                begin
                    if (!div_busy)
                    begin
                        state_reg <= S_WB;
                    end
                end
                S_WB:
                begin
                    keep_reg <= keep_reg + 7'd1;
                    if (pend_valid_reg)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        pend_reg <= new_item;
                        pend_valid_reg <= 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg <= {8'd0, pend_reg};
                        out_user_reg <= 1'b1;
                        out_last_reg <= 1'b0;
                        pend_reg <= new_item;
                        state_reg <= S_RD;
                    end
                end
                S_LAST:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg <= {8'd0, pend_reg};
                        out_user_reg <= 1'b1;
                        out_last_reg <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `include "particle_store_euler_step_core_macros.svh"
    `PSE_ASSERT_IMP(a_ready_idle, s_axis_tready, state_reg == S_IDLE, "ready while busy")
    `PSE_ASSERT_IMP(a_live_cap, 1'b1, live_reg <= 7'(MaxParticles), "live count overflow")
    `PSE_ASSERT_NEXT(a_emit_go, s_axis_tvalid && s_axis_tready, state_reg != S_IDLE,
        "accepted item not started")
    `PSE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "output item changed while stalled")
endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import pse_pkg::*;

    typedef struct {
        logic [1:0]  func;
        logic [31:0] px, py, pz, vx, vy, vz, rgba;
        logic [15:0] psize;
        logic [31:0] life;
        logic [6:0]  copies;
        logic [20:0] dt;
    } cmd_t;

    typedef struct {
        logic [31:0] x, y, z, rgba;
        logic [15:0] size;
        logic [6:0]  acc;
        logic        has;
        logic        last;
    } particle_out_t;

    localparam logic [1:0] FUNC_NONE = 2'd3;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [0:0]   cfg_index = '0;
    logic [23:0]  cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // lsb up: pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, rgba, point_size, life_span,
    // copies, time_step, pad
    logic [303:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;  // func
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // lsb up: out_x, out_y, out_z, out_rgba, out_size, accepted, pad
    logic [151:0] m_axis_tdata;
    logic         m_axis_tuser;       // has_particle
    logic         m_axis_tlast;

    particle_store_euler_step_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // particle store shadow
    logic [31:0] sh_pos[MaxParticles][3];
    logic [31:0] sh_vel[MaxParticles][3];
    logic [31:0] sh_rgba[MaxParticles];
    logic [15:0] sh_size[MaxParticles];
    logic [31:0] sh_life[MaxParticles];
    logic [31:0] sh_age[MaxParticles];
    int          sh_live = 0;
    logic [23:0] sh_gravity = GravityReset;
    logic [6:0]  sh_capacity = CapacityReset;

    particle_out_t expected_q[$];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          recv_hold = 0;

    function automatic logic [31:0] vel_times_step(logic [31:0] v, logic [20:0] dt);
        longint p;
        longint d;
        p = longint'($signed(v));
        d = dt;
        p = p * d;
        p = p >>> 16;
        return p[31:0];
    endfunction

    function automatic particle_out_t empty_out(logic [6:0] acc);
        particle_out_t r;
        r = '{default: '0};
        r.acc = acc;
        r.last = 1'b1;
        return r;
    endfunction

    task automatic add_expected(particle_out_t r);
        expected_q = {expected_q, r};
    endtask

    task automatic predict_step(cmd_t c);
        int cap, room, n, keep;
        longint unsigned age, fall, num, alpha, life;
        particle_out_t r;
        case (c.func)
            FUNC_EMIT:
            begin
                cap = (sh_capacity > MaxParticles) ? MaxParticles : sh_capacity;
                room = (sh_live < cap) ? cap - sh_live : 0;
                n = (c.copies > room) ? room : c.copies;
                for (int i = 0; i < n; i++)
                begin
                    sh_pos[sh_live] = '{c.px, c.py, c.pz};
                    sh_vel[sh_live] = '{c.vx, c.vy, c.vz};
                    sh_rgba[sh_live] = c.rgba;
                    sh_size[sh_live] = c.psize;
                    sh_life[sh_live] = c.life;
                    sh_age[sh_live] = '0;
                    sh_live++;
                end
                add_expected(empty_out(n[6:0]));
            end
            FUNC_TICK:
            begin
                fall = (longint'(sh_gravity) * longint'(c.dt)) >> 16;
                keep = 0;
                for (int i = 0; i < sh_live; i++)
                begin
                    age = longint'(sh_age[i]) + longint'(c.dt);
                    if (age > 64'hFFFF_FFFF)
                        age = 64'hFFFF_FFFF;
                    sh_age[i] = age[31:0];
                    life = sh_life[i];
                    if (age >= life)
                        continue;
                    for (int a = 0; a < 3; a++)
                        sh_pos[i][a] = sh_pos[i][a] + vel_times_step(sh_vel[i][a], c.dt);
                    sh_vel[i][1] = sh_vel[i][1] - fall[31:0];
                    num = 255 * (life - age);
                    alpha = num / life;
                    sh_rgba[i] = {sh_rgba[i][31:8], alpha[7:0]};
                    sh_pos[keep] = sh_pos[i];
                    sh_vel[keep] = sh_vel[i];
                    sh_rgba[keep] = sh_rgba[i];
                    sh_size[keep] = sh_size[i];
                    sh_life[keep] = sh_life[i];
                    sh_age[keep] = sh_age[i];
                    r = '{default: '0};
                    r.x = sh_pos[keep][0];
                    r.y = sh_pos[keep][1];
                    r.z = sh_pos[keep][2];
                    r.rgba = sh_rgba[keep];
                    r.size = sh_size[keep];
                    r.has = 1'b1;
                    add_expected(r);
                    keep++;
                end
                sh_live = keep;
                if (keep == 0)
                    add_expected(empty_out('0));
                else
                    expected_q[expected_q.size() - 1].last = 1'b1;
            end
            default:
            begin
                if (c.func == FUNC_CLEAR)
                    sh_live = 0;
                add_expected(empty_out('0));
            end
        endcase
    endtask

    task automatic send_cmd(cmd_t c);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tdata = {4'd0, c.dt, c.copies, c.life, c.psize, c.rgba,
                        c.vz, c.vy, c.vx, c.pz, c.py, c.px};
        s_axis_tuser = c.func;
        s_axis_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_step(c);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_idle();
        while (expected_q.size() != 0)
            @(negedge clk);
        // let the block settle before touching its registers
        repeat (100) @(negedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [23:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_GRAVITY)
            sh_gravity = value;
        else
            sh_capacity = value[6:0];
    endtask

    function automatic cmd_t rand_cmd(logic [1:0] func);
        cmd_t c;
        c.func = func;
        c.px = $urandom;
        c.py = $urandom;
        c.pz = $urandom;
        c.vx = $urandom;
        c.vy = $urandom;
        c.vz = $urandom;
        c.rgba = $urandom;
        c.psize = 16'($urandom);
        c.life = ($urandom_range(9) == 0) ? $urandom : $urandom_range(32'h60000);
        c.copies = 7'(($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(6));
        c.dt = 21'(($urandom_range(9) == 0) ? $urandom_range(1048576)
                                            : $urandom_range(65536));
        return c;
    endfunction

    function automatic cmd_t pick_cmd();
        int w;
        w = $urandom_range(99);
        if (w < 42)
            return rand_cmd(FUNC_EMIT);
        if (w < 92)
            return rand_cmd(FUNC_TICK);
        if (w < 97)
            return rand_cmd(FUNC_CLEAR);
        return rand_cmd(FUNC_NONE);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(negedge clk)
    begin
        if (recv_hold > 0)
        begin
            m_axis_tready = 1'b0;
            recv_hold--;
        end
        else
            m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        particle_out_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("unexpected item", m_axis_tdata[31:0], '0);
            else
            begin
                w = expected_q.pop_front();
                if (m_axis_tdata[31:0] !== w.x)
                    report_mismatch("out_x", m_axis_tdata[31:0], w.x);
                if (m_axis_tdata[63:32] !== w.y)
                    report_mismatch("out_y", m_axis_tdata[63:32], w.y);
                if (m_axis_tdata[95:64] !== w.z)
                    report_mismatch("out_z", m_axis_tdata[95:64], w.z);
                if (m_axis_tdata[127:96] !== w.rgba)
                    report_mismatch("out_rgba", m_axis_tdata[127:96], w.rgba);
                if (m_axis_tdata[143:128] !== w.size)
                    report_mismatch("out_size", 32'(m_axis_tdata[143:128]), 32'(w.size));
                if (m_axis_tdata[150:144] !== w.acc)
                    report_mismatch("accepted", 32'(m_axis_tdata[150:144]), 32'(w.acc));
                if (m_axis_tuser !== w.has)
                    report_mismatch("has_particle", 32'(m_axis_tuser), 32'(w.has));
                if (m_axis_tlast !== w.last)
                    report_mismatch("last", 32'(m_axis_tlast), 32'(w.last));
            end
        end
    end

    task automatic test_emit_extremes();
        cmd_t c;
        send_cmd(rand_cmd(FUNC_TICK));       // tick on an empty store
        c = rand_cmd(FUNC_EMIT);
        c.copies = 7'd0;
        send_cmd(c);
        c = rand_cmd(FUNC_EMIT);
        c.px = 32'h8000_0000; c.py = 32'h7FFF_FFFF; c.pz = '1;
        c.vx = 32'h7FFF_FFFF; c.vy = 32'h8000_0000; c.vz = '1;
        c.rgba = '1; c.psize = '1; c.life = '1; c.copies = 7'd64;
        send_cmd(c);
        send_cmd(c);                         // store full: accepts nothing
        c = rand_cmd(FUNC_TICK);
        c.dt = 21'd1048576;
        send_cmd(c);
        c.dt = 21'd0;
        send_cmd(c);
        send_cmd(rand_cmd(FUNC_NONE));
        send_cmd(rand_cmd(FUNC_CLEAR));
        send_cmd(rand_cmd(FUNC_TICK));
    endtask

    task automatic test_lifetime();
        cmd_t c;
        c = rand_cmd(FUNC_EMIT);
        c.life = 32'd0;
        c.copies = 7'd3;
        send_cmd(c);
        c = rand_cmd(FUNC_EMIT);
        c.life = 32'h0002_0000;
        c.copies = 7'd2;
        send_cmd(c);
        c = rand_cmd(FUNC_TICK);
        c.dt = 21'd0;
        send_cmd(c);                         // zero lifetime removed even with no step
        c.dt = 21'h01_0000;
        send_cmd(c);
        send_cmd(c);                         // age reaches lifetime exactly
    endtask

    task automatic test_capacity();
        cmd_t c;
        c = rand_cmd(FUNC_EMIT);
        c.copies = 7'd5;
        write_reg(REG_CAPACITY, 24'd0);
        send_cmd(c);
        wait_idle();
        write_reg(REG_CAPACITY, 24'd127);
        c.copies = 7'd64;
        send_cmd(c);
        send_cmd(rand_cmd(FUNC_CLEAR));
        wait_idle();
        write_reg(REG_CAPACITY, 24'd1);
        c.copies = 7'd3;
        send_cmd(c);
        send_cmd(c);
        wait_idle();
        write_reg(REG_CAPACITY, 24'd10);
        c.copies = 7'd20;
        send_cmd(c);
        send_cmd(rand_cmd(FUNC_CLEAR));
        wait_idle();
        write_reg(REG_CAPACITY, 24'(CapacityReset));
    endtask

    task automatic test_pressure();
        cmd_t c;
        c = rand_cmd(FUNC_EMIT);
        c.life = '1;
        c.copies = 7'd64;
        send_cmd(c);
        wait_idle();
        recv_hold = 3000;
        c = rand_cmd(FUNC_TICK);
        c.dt = 21'd16;
        for (int i = 0; i < 4; i++)
            send_cmd(c);
        send_cmd(rand_cmd(FUNC_CLEAR));
    endtask

    task automatic test_random(int n, int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < n; i++)
            send_cmd(pick_cmd());
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_emit_extremes();
        test_lifetime();
        wait_idle();
        write_reg(REG_GRAVITY, 24'd0);
        test_capacity();
        test_pressure();
        test_random(125, 0, 0);
        wait_idle();
        write_reg(REG_GRAVITY, 24'hFF_FFFF);
        write_reg(REG_CAPACITY, 24'd17);
        test_random(125, 49, 0);
        wait_idle();
        write_reg(REG_GRAVITY, 24'($urandom_range(24'hFF_FFFF)));
        write_reg(REG_CAPACITY, 24'd64);
        test_random(125, 0, 49);
        wait_idle();
        write_reg(REG_GRAVITY, GravityReset);
        test_random(125, 7, 7);
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("** particle_store_euler_step_core: PASSED **");
        else
            $display("** particle_store_euler_step_core: FAILED **");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("** particle_store_euler_step_core: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
